@@ design/srq_pkg.sv @@
// Shared types and constants for the selective-repeat ARQ sender.
package srq_pkg;

  localparam int unsigned BackoffCapMs = 16000;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_NACK = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_OUT_OF_WIN = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_WIN_SIZE     = 2'd0,
    CFG_BASE_TIMEOUT = 2'd1,
    CFG_OWNED_STRIDE = 2'd2,
    CFG_OWNED_OFFSET = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] seq_num;
    logic [11:0] frag_length;
    logic [31:0] current_time;
    logic [7:0]  send_budget;
    logic        link_refuses;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] tx_seq;
    logic [1:0]  status;
    logic [7:0]  retx_issued;
    logic [15:0] window_used;
    logic        window_full;
    logic        sender_failed;
    logic        last;
  } out_item_t;

  // Request to the shared modulo unit and its answer.
  typedef struct packed {
    logic        go;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  rem;
  } mod_rsp_t;

endpackage

@@ design/srq_mod_unit.sv @@
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
module srq_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  srq_pkg::mod_req_t req,
  output srq_pkg::mod_rsp_t rsp
);

  logic [15:0] dvd;
  logic [8:0]  rem;
  logic [7:0]  dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [8:0]  shifted;

  // Shift in the next dividend bit and subtract when it fits
  assign shifted = {rem[7:0], dvd[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[14:0], 1'b0};
        rem <= (shifted >= {1'b0, dvs}) ? shifted - {1'b0, dvs} : shifted;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem[7:0];

endmodule

@@ design/srq_ram.sv @@
// Generic single-port RAM with registered read.
module srq_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/selective_repeat_arq_sender.sv @@
// Selective-repeat ARQ sender: sequencer, slot state and shared modulo unit.
// A remainder (owner test or slot index) holds its state until the modulo unit is done.
// A tick walks at most WindowSlots slots; an ack walks each sequence that the base
// passes. One item at a time; busy is high until the done report; the receiver
// cannot stall. Sync reset restores the configuration defaults and clears the window,
// the slot flags and the failure flag.
module selective_repeat_arq_sender #(
  parameter int WindowSlots      = 32,
  parameter int RetryLimit       = 5,
  parameter int MaxFragmentBytes = 250
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  srq_pkg::in_item_t     in_item,
  output logic                  busy,
  output logic                  strobe,
  output srq_pkg::out_item_t    result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [13:0]           cfg_data
);

  localparam int SlotW = (WindowSlots > 1) ? $clog2(WindowSlots) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_OWN   = 8'b00000010,
    S_SLOT  = 8'b00000100,
    S_READ  = 8'b00001000,
    S_EVAL  = 8'b00010000,
    S_WRITE = 8'b00100000,
    S_NEXT  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;

  // Configuration
  logic [5:0]  win_size;
  logic [13:0] base_timeout;
  logic [7:0]  owned_stride;
  logic [7:0]  owned_offset;

  // Core state
  logic [15:0] base_seq, next_seq;
  logic        failed;
  logic [WindowSlots-1:0] vld, sent, acked;

  // Item in flight
  srq_pkg::in_item_t item;
  logic [15:0] cur;
  logic [8:0]  steps;
  logic [8:0]  step_i;
  logic [7:0]  retx;
  logic        owned;
  logic [SlotW-1:0] slot;
  logic [1:0]  stat;

  // Effective window
  logic [8:0] eff_win;
  always_comb begin
    if (win_size == 6'd0) begin
      eff_win = 9'd1;
    end else if ({3'd0, win_size} > 9'(WindowSlots)) begin
      eff_win = 9'(WindowSlots);
    end else begin
      eff_win = {3'd0, win_size};
    end
  end

  logic [15:0] used;
  assign used = next_seq - base_seq;

  // Next sequence and occupancy after a send
  logic [15:0] send_next;
  logic [15:0] send_used;
  assign send_next = ((item.seq_num - next_seq) < 16'h8000) ? item.seq_num + 16'd1 : next_seq;
  assign send_used = send_next - base_seq;

  // Shared remainder unit
  srq_pkg::mod_req_t mreq;
  srq_pkg::mod_rsp_t mrsp;
  srq_mod_unit u_mod (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  // Retry and time RAM
  logic             ram_we;
  logic [34:0]      ram_wdata, ram_rdata;
  logic [2:0]       rd_retries;
  logic [31:0]      rd_time;
  srq_ram #(.Width(35), .Depth(WindowSlots)) u_ram (
    .clk(clk), .we(ram_we), .addr(slot), .wdata(ram_wdata), .rdata(ram_rdata)
  );
  assign rd_retries = vld[slot] ? ram_rdata[34:32] : 3'd0;
  assign rd_time    = vld[slot] ? ram_rdata[31:0] : 32'd0;

  // Backoff: timeout shifted by retries, saturated
  logic [20:0] backoff_raw;
  logic [31:0] backoff;
  logic [31:0] age;
  logic        timed_out;
  assign backoff_raw = {7'd0, base_timeout} << rd_retries;
  assign backoff = (backoff_raw > 21'(srq_pkg::BackoffCapMs)) ?
                   32'(srq_pkg::BackoffCapMs) : {11'd0, backoff_raw};
  assign age = item.current_time - rd_time;
  assign timed_out = age >= backoff;

  logic [1:0] op;
  assign op = item.operation;

  logic mod_started;
  logic owned_cfg;
  assign owned_cfg = (owned_stride <= 8'd1);

  // Launch a remainder in the first cycle of an arithmetic state
  logic launch;
  assign launch = ((state == S_OWN && !owned_cfg) || (state == S_SLOT && owned)) &&
                  !mod_started;

  always_comb begin
    mreq.go       = launch;
    mreq.dividend = cur;
    mreq.divisor  = (state == S_SLOT) ? eff_win[7:0] : owned_stride;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      win_size     <= 6'd32;
      base_timeout <= 14'd2000;
      owned_stride <= 8'd1;
      owned_offset <= 8'd0;
      base_seq     <= '0;
      next_seq     <= '0;
      failed       <= 1'b0;
      vld          <= '0;
      sent         <= '0;
      acked        <= '0;
      strobe       <= 1'b0;
      mod_started  <= 1'b0;
      ram_we       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      ram_we <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          srq_pkg::CFG_WIN_SIZE:     win_size     <= cfg_data[5:0];
          srq_pkg::CFG_BASE_TIMEOUT: base_timeout <= cfg_data[13:0];
          srq_pkg::CFG_OWNED_STRIDE: owned_stride <= cfg_data[7:0];
          srq_pkg::CFG_OWNED_OFFSET: owned_offset <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            item   <= in_item;
            retx   <= '0;
            stat   <= srq_pkg::ST_OK;
            step_i <= '0;
            cur    <= (in_item.operation == srq_pkg::OP_TICK) ? base_seq : in_item.seq_num;
            owned  <= 1'b1;
            mod_started <= 1'b0;
            steps  <= (used > {7'd0, eff_win}) ? eff_win : used[8:0];
            if (in_item.operation == srq_pkg::OP_SEND &&
                in_item.frag_length > 12'(MaxFragmentBytes)) begin
              stat  <= srq_pkg::ST_TOO_LONG;
              state <= S_DONE;
            end else if ((in_item.operation == srq_pkg::OP_ACK ||
                          in_item.operation == srq_pkg::OP_NACK) &&
                         !((in_item.seq_num - base_seq) < used)) begin
              stat  <= srq_pkg::ST_OUT_OF_WIN;
              state <= S_DONE;
            end else if (in_item.operation == srq_pkg::OP_TICK && used == 16'd0) begin
              state <= S_DONE;
            end else if (in_item.operation == srq_pkg::OP_TICK) begin
              state <= S_OWN;
            end else begin
              state <= S_SLOT;
            end
          end
        end
        // Ownership test of cur, through the remainder unit when the stride is above 1
        S_OWN: begin
          if (owned_cfg) begin
            owned <= 1'b1;
            mod_started <= 1'b0;
            state <= S_SLOT;
          end else if (!mod_started) begin
            mod_started <= 1'b1;
          end else if (mrsp.done) begin
            owned <= (mrsp.rem == owned_offset);
            mod_started <= 1'b0;
            state <= S_SLOT;
          end
        end
        // Slot index of cur
        S_SLOT: begin
          if (!owned) begin
            state <= S_NEXT;
          end else if (!mod_started) begin
            mod_started <= 1'b1;
          end else if (mrsp.done) begin
            slot <= SlotW'(mrsp.rem);
            mod_started <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          state <= S_NEXT;
          case (op)
            srq_pkg::OP_SEND: begin
              sent[slot]  <= 1'b1;
              acked[slot] <= 1'b0;
              vld[slot]   <= 1'b1;
              ram_wdata   <= {3'd0, item.current_time};
              ram_we      <= 1'b1;
              next_seq    <= send_next;
              strobe <= 1'b1;
              result <= '{kind: 1'b0, tx_seq: item.seq_num, status: 2'd0, retx_issued: 8'd0,
                          window_used: send_used,
                          window_full: ({1'b0, send_used} >= {8'd0, eff_win}),
                          sender_failed: failed, last: 1'b0};
              state <= S_WRITE;
            end
            srq_pkg::OP_ACK: begin
              if (step_i == 9'd0) begin
                acked[slot] <= 1'b1;
                step_i <= 9'd1;
                cur <= base_seq;
                state <= (base_seq == next_seq) ? S_DONE : S_OWN;
              end else if (!acked[slot]) begin
                state <= S_DONE;
              end else begin
                sent[slot] <= 1'b0;
                state <= S_NEXT;
              end
            end
            srq_pkg::OP_NACK: begin
              if (rd_retries >= 3'(RetryLimit)) begin
                stat  <= srq_pkg::ST_EXHAUSTED;
                state <= S_DONE;
              end else begin
                vld[slot] <= 1'b1;
                ram_wdata <= {rd_retries + 3'd1, item.current_time};
                ram_we    <= 1'b1;
                strobe <= 1'b1;
                result <= '{kind: 1'b0, tx_seq: item.seq_num, status: 2'd0, retx_issued: 8'd0,
                            window_used: used, window_full: ({1'b0, used} >= {8'd0, eff_win}),
                            sender_failed: failed, last: 1'b0};
                state <= S_WRITE;
              end
            end
            default: begin
              if (sent[slot] && !acked[slot] && timed_out) begin
                if (rd_retries >= 3'(RetryLimit)) begin
                  failed <= 1'b1;
                end else if (retx >= item.send_budget || item.link_refuses) begin
                  state <= S_DONE;
                end else begin
                  vld[slot] <= 1'b1;
                  ram_wdata <= {rd_retries + 3'd1, item.current_time};
                  ram_we    <= 1'b1;
                  retx   <= retx + 8'd1;
                  strobe <= 1'b1;
                  result <= '{kind: 1'b0, tx_seq: cur, status: 2'd0, retx_issued: 8'd0,
                              window_used: used,
                              window_full: ({1'b0, used} >= {8'd0, eff_win}),
                              sender_failed: failed, last: 1'b0};
                end
              end
            end
          endcase
        end
        S_WRITE: state <= S_DONE;
        // Advance the walk: ack moves base, tick moves the cursor
        S_NEXT: begin
          if (op == srq_pkg::OP_ACK) begin
            if (base_seq + 16'd1 == next_seq) begin
              base_seq <= base_seq + 16'd1;
              state <= S_DONE;
            end else begin
              base_seq <= base_seq + 16'd1;
              cur <= base_seq + 16'd1;
              state <= S_OWN;
            end
          end else if (op == srq_pkg::OP_TICK && step_i + 9'd1 < steps) begin
            step_i <= step_i + 9'd1;
            cur <= cur + 16'd1;
            state <= S_OWN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          strobe <= 1'b1;
          result <= '{kind: 1'b1,
                      tx_seq: (op == srq_pkg::OP_TICK) ? 16'd0 : item.seq_num,
                      status: stat,
                      retx_issued: (op == srq_pkg::OP_TICK) ? retx : 8'd0,
                      window_used: used,
                      window_full: ({1'b0, used} >= {8'd0, eff_win}),
                      sender_failed: failed, last: 1'b1};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy) else $error("done report not at end");
  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.kind == result.last)) else $error("kind/last mismatch");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> busy) else $error("busy low while working");
`endif

endmodule

@@ tb/tb_selective_repeat_arq_sender.sv @@
// Testbench for the selective-repeat ARQ sender: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_selective_repeat_arq_sender;

  localparam int unsigned NumSlots   = 32;
  localparam int unsigned RetryMax   = 5;
  localparam int unsigned MaxFragLen = 250;
  localparam int unsigned CycleLimit = 3000000;

  logic      clk;
  logic      rst;
  logic      start;
  srq_pkg::in_item_t  in_item;
  logic      busy;
  logic      strobe;
  srq_pkg::out_item_t result;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [13:0] cfg_data;

  selective_repeat_arq_sender i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .strobe    (strobe),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the sender: registers and slot table
  int unsigned win_reg, tmo_reg, stride_reg, offset_reg;
  logic [15:0] head_seq, tail_seq;
  logic        link_failed;
  logic        sl_sent  [NumSlots];
  logic        sl_acked [NumSlots];
  int unsigned sl_tries [NumSlots];
  logic [31:0] sl_stamp [NumSlots];

  srq_pkg::out_item_t pending_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  logic [31:0] now_ms;

  function automatic int unsigned active_window();
    if (win_reg < 1) return 1;
    if (win_reg > NumSlots) return NumSlots;
    return win_reg;
  endfunction

  function automatic int unsigned slot_for(logic [15:0] s);
    return int'(s) % active_window();
  endfunction

  function automatic logic owns(logic [15:0] s);
    if (stride_reg <= 1) return 1'b1;
    return (int'(s) % stride_reg) == offset_reg;
  endfunction

  function automatic logic [15:0] in_flight();
    return tail_seq - head_seq;
  endfunction

  function automatic void queue_result(logic kind, logic [15:0] s, srq_pkg::status_t st,
                                       logic [7:0] retx);
    srq_pkg::out_item_t r;
    r.kind          = kind;
    r.tx_seq        = s;
    r.status        = st;
    r.retx_issued   = retx;
    r.window_used   = in_flight();
    r.window_full   = (int'(in_flight()) >= active_window());
    r.sender_failed = link_failed;
    r.last          = kind;
    pending_q.push_back(r);
  endfunction

  function automatic logic inside_window(logic [15:0] s);
    return logic'(16'(s - head_seq) < in_flight());
  endfunction

  // Work out the results of one accepted transfer and update the shadow state
  function automatic void predict_transfer(srq_pkg::in_item_t it);
    int unsigned idx, steps, retx, backoff;
    logic [15:0] s;
    case (srq_pkg::op_t'(it.operation))
      srq_pkg::OP_SEND: begin
        if (it.frag_length > MaxFragLen) begin
          queue_result(1'b1, it.seq_num, srq_pkg::ST_TOO_LONG, 8'd0);
        end else begin
          idx = slot_for(it.seq_num);
          sl_stamp[idx] = it.current_time;
          sl_acked[idx] = 1'b0;
          sl_sent[idx]  = 1'b1;
          sl_tries[idx] = 0;
          if (16'(it.seq_num - tail_seq) < 16'h8000) tail_seq = it.seq_num + 16'd1;
          queue_result(1'b0, it.seq_num, srq_pkg::ST_OK, 8'd0);
          queue_result(1'b1, it.seq_num, srq_pkg::ST_OK, 8'd0);
        end
      end
      srq_pkg::OP_ACK: begin
        if (!inside_window(it.seq_num)) begin
          queue_result(1'b1, it.seq_num, srq_pkg::ST_OUT_OF_WIN, 8'd0);
        end else begin
          sl_acked[slot_for(it.seq_num)] = 1'b1;
          while (head_seq != tail_seq) begin
            if (owns(head_seq)) begin
              idx = slot_for(head_seq);
              if (!sl_acked[idx]) break;
              sl_sent[idx] = 1'b0;
            end
            head_seq++;
          end
          queue_result(1'b1, it.seq_num, srq_pkg::ST_OK, 8'd0);
        end
      end
      srq_pkg::OP_NACK: begin
        if (!inside_window(it.seq_num)) begin
          queue_result(1'b1, it.seq_num, srq_pkg::ST_OUT_OF_WIN, 8'd0);
        end else begin
          idx = slot_for(it.seq_num);
          if (sl_tries[idx] >= RetryMax) begin
            queue_result(1'b1, it.seq_num, srq_pkg::ST_EXHAUSTED, 8'd0);
          end else begin
            sl_tries[idx] = (sl_tries[idx] + 1) & 7;
            sl_stamp[idx] = it.current_time;
            queue_result(1'b0, it.seq_num, srq_pkg::ST_OK, 8'd0);
            queue_result(1'b1, it.seq_num, srq_pkg::ST_OK, 8'd0);
          end
        end
      end
      default: begin
        steps = in_flight();
        retx  = 0;
        if (steps > active_window()) steps = active_window();
        for (int unsigned i = 0; i < steps; i++) begin
          s = head_seq + 16'(i);
          if (!owns(s)) continue;
          idx = slot_for(s);
          if (!sl_sent[idx] || sl_acked[idx]) continue;
          backoff = tmo_reg << sl_tries[idx];
          if (backoff > srq_pkg::BackoffCapMs) backoff = srq_pkg::BackoffCapMs;
          if (32'(it.current_time - sl_stamp[idx]) >= backoff) begin
            if (sl_tries[idx] >= RetryMax) begin
              link_failed = 1'b1;
              continue;
            end
            if (retx >= it.send_budget) break;
            if (it.link_refuses) break;
            queue_result(1'b0, s, srq_pkg::ST_OK, 8'd0);
            sl_tries[idx] = (sl_tries[idx] + 1) & 7;
            sl_stamp[idx] = it.current_time;
            retx++;
          end
        end
        queue_result(1'b1, 16'd0, srq_pkg::ST_OK, 8'(retx));
      end
    endcase
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    srq_pkg::out_item_t want;
    if (!rst && strobe) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        want = pending_q.pop_front();
        if (result.kind !== want.kind || result.tx_seq !== want.tx_seq ||
            result.status !== want.status || result.retx_issued !== want.retx_issued ||
            result.window_used !== want.window_used ||
            result.window_full !== want.window_full ||
            result.sender_failed !== want.sender_failed || result.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, result);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold start until the sender is idle, take the transfer at the next edge, predict it
  task automatic issue(srq_pkg::in_item_t it);
    start   = 1'b1;
    in_item = it;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_transfer(it);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(srq_pkg::cfg_idx_t idx, int unsigned value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = 14'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      srq_pkg::CFG_WIN_SIZE:     win_reg    = value & 'h3F;
      srq_pkg::CFG_BASE_TIMEOUT: tmo_reg    = value & 'h3FFF;
      srq_pkg::CFG_OWNED_STRIDE: stride_reg = value & 'hFF;
      default:                   offset_reg = value & 'hFF;
    endcase
  endtask

  // Directed rows; pinned rows carry a status that is known at a glance
  typedef struct {
    srq_pkg::op_t     op;
    logic [15:0]      seq;
    logic [11:0]      len;
    logic [31:0]      ms;
    logic [7:0]       budget;
    logic             refuse;
    logic             pinned;
    srq_pkg::status_t pin_status;
  } row_t;

  row_t rows[$];

  function automatic void add_row(srq_pkg::op_t op, logic [15:0] seq, logic [11:0] len,
                                  logic [31:0] ms, logic [7:0] budget, logic refuse,
                                  logic pinned = 1'b0,
                                  srq_pkg::status_t pin_status = srq_pkg::ST_OK);
    row_t r;
    r = '{op, seq, len, ms, budget, refuse, pinned, pin_status};
    rows.push_back(r);
  endfunction

  function automatic logic [15:0] pick_in_window();
    int unsigned span;
    span = in_flight();
    if (span == 0) return head_seq;
    if (span > 40) span = 40;
    return head_seq + 16'($urandom_range(0, span - 1));
  endfunction

  // Random transfer, mostly well-formed traffic around the window
  function automatic srq_pkg::in_item_t random_item();
    srq_pkg::in_item_t it;
    int unsigned pick, p;
    it = srq_pkg::in_item_t'(71'({$urandom, $urandom, $urandom}));
    now_ms += $urandom_range(0, 2500);
    if ($urandom_range(0, 9) == 0) now_ms += $urandom_range(10000, 40000);
    if ($urandom_range(0, 49) == 0) now_ms = $urandom;
    it.current_time = now_ms;
    pick = $urandom_range(0, 99);
    p    = $urandom_range(0, 9);
    if (pick < 40) begin
      it.operation = srq_pkg::OP_SEND;
      if (p < 7) it.seq_num = tail_seq + 16'($urandom_range(0, 1));
      else if (p == 7) it.seq_num = tail_seq + 16'($urandom_range(2, 64));
      else it.seq_num = tail_seq - 16'($urandom_range(1, 32768));
      it.frag_length = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(251, 4095))
                                                   : 12'($urandom_range(0, 250));
    end else if (pick < 80) begin
      it.operation = (pick < 65) ? srq_pkg::OP_ACK : srq_pkg::OP_NACK;
      if (p < 8) it.seq_num = pick_in_window();
    end else begin
      it.operation    = srq_pkg::OP_TICK;
      it.send_budget  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      it.link_refuses = ($urandom_range(0, 9) == 0);
    end
    return it;
  endfunction

  int unsigned phase_cfg[6][4] = '{
    '{32, 2000, 1, 0}, '{1, 0, 1, 0}, '{0, 16383, 3, 1},
    '{63, 16000, 255, 254}, '{8, 500, 2, 5}, '{12, 1000, 0, 0}
  };

  initial begin
    srq_pkg::in_item_t it;
    logic quiet;
    rst = 1'b1; start = 1'b0; in_item = '0;
    cfg_we = 1'b0; cfg_index = srq_pkg::CFG_WIN_SIZE; cfg_data = '0;
    mismatches = 0; cycles = 0; now_ms = 0;
    win_reg = 32; tmo_reg = 2000; stride_reg = 1; offset_reg = 0;
    head_seq = 0; tail_seq = 0; link_failed = 1'b0;
    for (int i = 0; i < NumSlots; i++) begin
      sl_sent[i] = 0; sl_acked[i] = 0; sl_tries[i] = 0; sl_stamp[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset settings
    add_row(srq_pkg::OP_ACK, 16'd0, 12'd0, 32'd0, 8'd0, 1'b0, 1'b1, srq_pkg::ST_OUT_OF_WIN);
    add_row(srq_pkg::OP_NACK, 16'd5, 12'd0, 32'd0, 8'd0, 1'b0, 1'b1, srq_pkg::ST_OUT_OF_WIN);
    add_row(srq_pkg::OP_TICK, 16'hFFFF, 12'hFFF, 32'd0, 8'd0, 1'b1, 1'b1, srq_pkg::ST_OK);
    add_row(srq_pkg::OP_SEND, 16'd0, 12'd251, 32'd0, 8'd0, 1'b0, 1'b1, srq_pkg::ST_TOO_LONG);
    add_row(srq_pkg::OP_SEND, 16'd0, 12'd4095, 32'd0, 8'd0, 1'b0, 1'b1, srq_pkg::ST_TOO_LONG);
    add_row(srq_pkg::OP_SEND, 16'd0,     12'd250,  32'd100,    8'd0,   1'b0);
    add_row(srq_pkg::OP_SEND, 16'd1,     12'd0,    32'd100,    8'd0,   1'b0);
    add_row(srq_pkg::OP_SEND, 16'd2,     12'd7,    32'd100,    8'd0,   1'b0);
    add_row(srq_pkg::OP_NACK, 16'd1,     12'd0,    32'd200,    8'd0,   1'b0);
    add_row(srq_pkg::OP_TICK, 16'd0,     12'd0,    32'd2100,   8'd255, 1'b0);
    add_row(srq_pkg::OP_TICK, 16'd0,     12'd0,    32'd9000,   8'd1,   1'b0);
    add_row(srq_pkg::OP_TICK, 16'd0,     12'd0,    32'd20000,  8'd8,   1'b1);
    add_row(srq_pkg::OP_ACK,  16'd1,     12'd0,    32'd20000,  8'd0,   1'b0);
    add_row(srq_pkg::OP_ACK,  16'd0,     12'd0,    32'd20000,  8'd0,   1'b0);
    for (int i = 0; i < 6; i++)
      add_row(srq_pkg::OP_NACK, 16'd2, 12'd0, 32'd21000, 8'd0, 1'b0);
    add_row(srq_pkg::OP_TICK, 16'd0,     12'd0,    32'hFFFFFFFF, 8'd255, 1'b0);
    add_row(srq_pkg::OP_SEND, 16'hFFFF,  12'd1,    32'hFFFFFFFF, 8'd0,   1'b0);
    add_row(srq_pkg::OP_ACK, 16'hFFFF, 12'd0, 32'd0, 8'd0, 1'b0, 1'b1, srq_pkg::ST_OUT_OF_WIN);
    add_row(srq_pkg::OP_SEND, 16'd3,     12'd9,    32'd5,      8'd0,   1'b0);
    add_row(srq_pkg::OP_ACK,  16'd3,     12'd0,    32'd6,      8'd0,   1'b0);
    foreach (rows[i]) begin
      it = '0;
      it.operation    = rows[i].op;
      it.seq_num      = rows[i].seq;
      it.frag_length  = rows[i].len;
      it.current_time = rows[i].ms;
      it.send_budget  = rows[i].budget;
      it.link_refuses = rows[i].refuse;
      issue(it);
      if (rows[i].pinned) pending_q[pending_q.size() - 1].status = rows[i].pin_status;
    end
    now_ms = 32'd100;

    // Random phases, one register setting each; the sender drains before each phase's writes
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(srq_pkg::CFG_WIN_SIZE,     phase_cfg[ph][0]);
      write_reg(srq_pkg::CFG_BASE_TIMEOUT, phase_cfg[ph][1]);
      write_reg(srq_pkg::CFG_OWNED_STRIDE, phase_cfg[ph][2]);
      write_reg(srq_pkg::CFG_OWNED_OFFSET, phase_cfg[ph][3]);
      quiet = (ph == 5);
      for (int n = 0; n < 34; n++) begin
        if (!quiet && $urandom_range(0, 3) == 0) begin
          start = 1'b0;
          repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        issue(random_item());
      end
    end
    start = 1'b0;

    // Let the last results arrive
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
